[hdl/mer_pkg.sv]
// Shared types and codes for the midpoint ellipse rasterizer.
// No dependencies; the sequencer, the top level and the bench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // action field codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_RXRY,
    ST_START_FIN,
    ST_STEP,
    ST_R2_TX,
    ST_R2_A,
    ST_R2_TY,
    ST_R2_B,
    ST_R2_C,
    ST_R2_FIN
  } state_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MS_RX_RX,
    MS_RY_RY,
    MS_RXSQ_RY,
    MS_TX_TX,
    MS_RYSQ_P,
    MS_TY_TY,
    MS_RXSQ_P,
    MS_RXSQ_RYSQ
  } mul_sel_t;

  typedef struct packed {
    logic in_valid;
    logic action;
    logic active;
    logic r1_cond;   // still in region 1 and slope below 1
    logic in_r2;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic     in_ready;
    mul_sel_t mul_sel;
    logic     ld_rx_sq;
    logic     ld_ry_sq;
    logic     start_emit;
    logic     step_emit;
    logic     dec_load;
    logic     dec_add;
    logic     dec_fin;
  } ctrl_t;

endpackage

`default_nettype wire

[hdl/mer_in_if.sv]
// Input channel of the ellipse rasterizer: start/advance items.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface mer_in_if #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  modport source (
    output valid, action, center_x, center_y, radius_x, radius_y,
    input  ready
  );
  modport sink (
    input  valid, action, center_x, center_y, radius_x, radius_y,
    output ready
  );
endinterface

`default_nettype wire

[hdl/mer_out_if.sv]
// Output channel of the ellipse rasterizer: one point record per transfer.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface mer_out_if #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] right_x;
  logic signed [COORD_BITS+1:0] left_x;
  logic signed [COORD_BITS+1:0] lower_y;
  logic signed [COORD_BITS+1:0] upper_y;
  logic [RADIUS_BITS-1:0]       offset_x;
  logic [RADIUS_BITS-1:0]       offset_y;
  logic                         point_valid;
  logic                         last;

  modport source (
    output valid, right_x, left_x, lower_y, upper_y, offset_x, offset_y,
           point_valid, last,
    input  ready
  );
  modport sink (
    input  valid, right_x, left_x, lower_y, upper_y, offset_x, offset_y,
           point_valid, last,
    output ready
  );
endinterface

`default_nettype wire

[hdl/mer_mul.sv]
// Shared multiplier of the ellipse rasterizer, product registered.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module mer_mul #(
  parameter int A_W = 18,
  parameter int B_W = 20
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output      logic [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

[hdl/mer_ctrl.sv]
// Sequencer of the ellipse rasterizer: start, step and region-2 setup.
// Uses mer_pkg state, status and control types.
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mer_pkg::status_t sts,
  output      mer_pkg::ctrl_t   ctl
);

  mer_pkg::state_t state, state_next;
  logic            step_emits;

  // a step item emits its record unless it must set up region 2 first
  assign step_emits = !sts.active || sts.r1_cond || sts.in_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mer_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mer_pkg::ST_IDLE: begin
        if (sts.in_valid) begin
          state_next = (sts.action == mer_pkg::ACT_ADVANCE) ? mer_pkg::ST_STEP
                                                            : mer_pkg::ST_SQ_RX;
        end
      end
      mer_pkg::ST_SQ_RX:     state_next = mer_pkg::ST_SQ_RY;
      mer_pkg::ST_SQ_RY:     state_next = mer_pkg::ST_RXRY;
      mer_pkg::ST_RXRY:      state_next = mer_pkg::ST_START_FIN;
      mer_pkg::ST_START_FIN: begin
        if (sts.out_free) state_next = mer_pkg::ST_IDLE;
      end
      mer_pkg::ST_STEP: begin
        if (!step_emits) begin
          state_next = mer_pkg::ST_R2_TX;
        end else if (sts.out_free) begin
          state_next = mer_pkg::ST_IDLE;
        end
      end
      mer_pkg::ST_R2_TX:  state_next = mer_pkg::ST_R2_A;
      mer_pkg::ST_R2_A:   state_next = mer_pkg::ST_R2_TY;
      mer_pkg::ST_R2_TY:  state_next = mer_pkg::ST_R2_B;
      mer_pkg::ST_R2_B:   state_next = mer_pkg::ST_R2_C;
      mer_pkg::ST_R2_C:   state_next = mer_pkg::ST_R2_FIN;
      mer_pkg::ST_R2_FIN: state_next = mer_pkg::ST_STEP;
      default:            state_next = mer_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.mul_sel    = mer_pkg::MS_RX_RX;
    case (state)
      mer_pkg::ST_IDLE:      ctl.in_ready = 1'b1;
      mer_pkg::ST_SQ_RX:     ctl.mul_sel  = mer_pkg::MS_RX_RX;
      mer_pkg::ST_SQ_RY: begin
        ctl.mul_sel  = mer_pkg::MS_RY_RY;
        ctl.ld_rx_sq = 1'b1;
      end
      mer_pkg::ST_RXRY: begin
        ctl.mul_sel  = mer_pkg::MS_RXSQ_RY;
        ctl.ld_ry_sq = 1'b1;
      end
      // keep rx^2*ry on the product while the output is stalled
      mer_pkg::ST_START_FIN: begin
        ctl.mul_sel    = mer_pkg::MS_RXSQ_RY;
        ctl.start_emit = sts.out_free;
      end
      mer_pkg::ST_STEP:      ctl.step_emit  = step_emits && sts.out_free;
      mer_pkg::ST_R2_TX:     ctl.mul_sel    = mer_pkg::MS_TX_TX;
      mer_pkg::ST_R2_A:      ctl.mul_sel    = mer_pkg::MS_RYSQ_P;
      mer_pkg::ST_R2_TY: begin
        ctl.mul_sel  = mer_pkg::MS_TY_TY;
        ctl.dec_load = 1'b1;
      end
      mer_pkg::ST_R2_B:      ctl.mul_sel    = mer_pkg::MS_RXSQ_P;
      mer_pkg::ST_R2_C: begin
        ctl.mul_sel = mer_pkg::MS_RXSQ_RYSQ;
        ctl.dec_add = 1'b1;
      end
      mer_pkg::ST_R2_FIN:    ctl.dec_fin    = 1'b1;
      default:               ctl.in_ready   = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer: top level with datapath and output register.
// Depends on mer_pkg, mer_in_if, mer_out_if, mer_mul and mer_ctrl.
//
// Usage: items arrive on cmd (valid/ready). A start item (action 0) latches
// centre and radii and returns the point (0, radius_y); each advance item
// (action 1) returns the next point of the first quadrant with its four
// mirrored coordinates on pix. An advance with no ellipse in progress
// returns an all-zero record with point_valid low. last marks offset_y zero.
// Timing: cmd is taken only when the sequencer is idle. An advance passes
// the step state on its way to the result register; the advance that crosses
// into region 2 runs the region-2 setup states before its step, since the
// region-2 decision is built from five products through the one shared
// multiplier. A start builds three products first. Every item gives exactly
// one result, and a new item is taken only once the last has reached the result register.
// The result sits in an output register; the next item is accepted while it
// waits, and its result is held back until pix takes the previous one.
// Reset (rst, synchronous) leaves the block idle with no ellipse in progress.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input wire logic  clk,
  input wire logic  rst,
  mer_in_if.sink    cmd,
  mer_out_if.source pix
);

  localparam int A_W   = 2 * RADIUS_BITS;
  localparam int B_W   = 2 * RADIUS_BITS + 2;
  localparam int P_W   = A_W + B_W;
  localparam int SL_W  = 3 * RADIUS_BITS + 2;
  localparam int DEC_W = 4 * RADIUS_BITS + 6;
  localparam int OUT_W = COORD_BITS + 2;
  localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  mer_pkg::status_t sts;
  mer_pkg::ctrl_t   ctl;

  logic [COORD_BITS-1:0]  centre_col, centre_row;
  logic [RADIUS_BITS-1:0] rad_x;
  logic [A_W-1:0]         rx_sq, ry_sq;
  logic [RADIUS_BITS-1:0] cur_x, cur_y;
  logic [SL_W-1:0]        slope_x, slope_y;
  logic [DEC_W-1:0]       decision;
  logic                   in_r2, active;

  logic [A_W-1:0] mul_a;
  logic [B_W-1:0] mul_b;
  logic [P_W-1:0] prod;

  logic                   cmd_fire, out_free;
  logic [RADIUS_BITS:0]   tx;
  logic [RADIUS_BITS-1:0] ty, x_inc;
  logic [SL_W-1:0]        sx_inc, sy_dec;
  logic [DEC_W-1:0]       rxsq_d, rysq_d, sxinc_d, sydec_d, step_t, prod4;
  logic                   dec_neg;

  logic [RADIUS_BITS-1:0] x_n, y_n;
  logic [SL_W-1:0]        sx_n, sy_n;
  logic [DEC_W-1:0]       d_n, d_start;

  logic [RADIUS_BITS-1:0] emit_x, emit_y;
  logic                   emit_pv, emit_last;
  logic [SUM_W-1:0]       cx_w, cy_w, ex_w, ey_w, rx_w, lx_w, ly_w, uy_w;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !pix.valid || pix.ready;
  assign cmd.ready = ctl.in_ready;

  assign sts.in_valid = cmd.valid;
  assign sts.action   = cmd.action;
  assign sts.active   = active;
  assign sts.r1_cond  = !in_r2 && (slope_x < slope_y);
  assign sts.in_r2    = in_r2;
  assign sts.out_free = out_free;

  mer_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  // operand selection for the shared multiplier
  assign tx = {cur_x, 1'b1};
  assign ty = cur_y - RADIUS_BITS'(1);

  always_comb begin
    case (ctl.mul_sel)
      mer_pkg::MS_RX_RX: begin
        mul_a = A_W'(rad_x);
        mul_b = B_W'(rad_x);
      end
      mer_pkg::MS_RY_RY: begin
        mul_a = A_W'(cur_y);
        mul_b = B_W'(cur_y);
      end
      mer_pkg::MS_RXSQ_RY: begin
        mul_a = rx_sq;
        mul_b = B_W'(cur_y);
      end
      mer_pkg::MS_TX_TX: begin
        mul_a = A_W'(tx);
        mul_b = B_W'(tx);
      end
      mer_pkg::MS_RYSQ_P: begin
        mul_a = ry_sq;
        mul_b = prod[B_W-1:0];
      end
      mer_pkg::MS_TY_TY: begin
        mul_a = A_W'(ty);
        mul_b = B_W'(ty);
      end
      mer_pkg::MS_RXSQ_P: begin
        mul_a = rx_sq;
        mul_b = prod[B_W-1:0];
      end
      mer_pkg::MS_RXSQ_RYSQ: begin
        mul_a = rx_sq;
        mul_b = B_W'(ry_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mer_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // one midpoint step, region chosen by r1_cond
  assign x_inc   = cur_x + RADIUS_BITS'(1);
  assign sx_inc  = slope_x + SL_W'({ry_sq, 1'b0});
  assign sy_dec  = slope_y - SL_W'({rx_sq, 1'b0});
  assign rxsq_d  = DEC_W'(rx_sq);
  assign rysq_d  = DEC_W'(ry_sq);
  assign sxinc_d = DEC_W'(sx_inc);
  assign sydec_d = DEC_W'(sy_dec);
  assign dec_neg = decision[DEC_W-1];
  assign prod4   = DEC_W'({prod, 2'b00});

  always_comb begin
    x_n    = cur_x;
    y_n    = cur_y;
    sx_n   = slope_x;
    sy_n   = slope_y;
    step_t = '0;
    if (sts.r1_cond) begin
      x_n  = x_inc;
      sx_n = sx_inc;
      if (dec_neg) begin
        step_t = rysq_d + sxinc_d;
      end else begin
        y_n    = ty;
        sy_n   = sy_dec;
        step_t = rysq_d + sxinc_d - sydec_d;
      end
    end else begin
      y_n  = ty;
      sy_n = sy_dec;
      if (!dec_neg && (decision != '0)) begin
        step_t = rxsq_d - sydec_d;
      end else begin
        x_n    = x_inc;
        sx_n   = sx_inc;
        step_t = rxsq_d - sydec_d + sxinc_d;
      end
    end
    d_n = decision + {step_t[DEC_W-3:0], 2'b00};
  end

  // region 1 start: 4*ry^2 - 4*rx^2*ry + rx^2, with prod = rx^2*ry
  assign d_start = {rysq_d[DEC_W-3:0], 2'b00} - prod4 + rxsq_d;

  always_ff @(posedge clk) begin
    if (cmd_fire && (cmd.action == mer_pkg::ACT_START)) begin
      centre_col <= cmd.center_x;
      centre_row <= cmd.center_y;
      rad_x      <= cmd.radius_x;
      cur_y      <= cmd.radius_y;
    end
    if (ctl.ld_rx_sq) rx_sq <= prod[A_W-1:0];
    if (ctl.ld_ry_sq) ry_sq <= prod[A_W-1:0];
    if (ctl.start_emit) begin
      cur_x    <= '0;
      slope_x  <= '0;
      slope_y  <= {prod[SL_W-2:0], 1'b0};
      decision <= d_start;
    end
    if (ctl.dec_load) decision <= DEC_W'(prod);
    if (ctl.dec_add)  decision <= decision + prod4;
    if (ctl.dec_fin)  decision <= decision - prod4;
    if (ctl.step_emit && active) begin
      cur_x    <= x_n;
      cur_y    <= y_n;
      slope_x  <= sx_n;
      slope_y  <= sy_n;
      decision <= d_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      in_r2  <= 1'b0;
    end else begin
      if (ctl.start_emit) begin
        active <= (cur_y != '0);
        in_r2  <= 1'b0;
      end
      if (ctl.dec_fin) in_r2 <= 1'b1;
      if (ctl.step_emit && active) active <= (y_n != '0);
    end
  end

  // result record
  always_comb begin
    emit_x    = '0;
    emit_y    = '0;
    emit_pv   = 1'b0;
    emit_last = 1'b0;
    if (ctl.start_emit) begin
      emit_y    = cur_y;
      emit_pv   = 1'b1;
      emit_last = (cur_y == '0);
    end else if (active) begin
      emit_x    = x_n;
      emit_y    = y_n;
      emit_pv   = 1'b1;
      emit_last = (y_n == '0);
    end
  end

  assign cx_w = emit_pv ? SUM_W'(centre_col) : '0;
  assign cy_w = emit_pv ? SUM_W'(centre_row) : '0;
  assign ex_w = SUM_W'(emit_x);
  assign ey_w = SUM_W'(emit_y);
  assign rx_w = cx_w + ex_w;
  assign lx_w = cx_w - ex_w;
  assign ly_w = cy_w + ey_w;
  assign uy_w = cy_w - ey_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (ctl.start_emit || ctl.step_emit) begin
      pix.valid <= 1'b1;
    end else if (pix.ready) begin
      pix.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_emit || ctl.step_emit) begin
      pix.right_x     <= rx_w[OUT_W-1:0];
      pix.left_x      <= lx_w[OUT_W-1:0];
      pix.lower_y     <= ly_w[OUT_W-1:0];
      pix.upper_y     <= uy_w[OUT_W-1:0];
      pix.offset_x    <= emit_x;
      pix.offset_y    <= emit_y;
      pix.point_valid <= emit_pv;
      pix.last        <= emit_last;
    end
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctl.start_emit || ctl.step_emit) |-> out_free)
    else $error("result register overwritten while still pending");

  // the last point always has y offset zero and is a real point
  a_last_point: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.last) |-> (pix.point_valid && (pix.offset_y == '0)))
    else $error("last point with nonzero y offset");

  // an empty record carries no offsets
  a_empty_record: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix.point_valid) |->
      ((pix.offset_x == '0) && (pix.offset_y == '0) && !pix.last))
    else $error("empty record carries point data");

  // region 2 is left only by a new start
  a_region_sticky: assert property (@(posedge clk) disable iff (rst)
    (in_r2 && !ctl.start_emit) |=> in_r2)
    else $error("region 2 flag dropped without a start");

endmodule

`default_nettype wire

[bench/tb_midpoint_ellipse_rasterizer.sv]
// Self-checking bench for midpoint_ellipse_rasterizer: drives start/advance
// items on cmd, predicts every point record and checks each one taken from pix.
// Depends on mer_pkg, mer_in_if, mer_out_if and the rasterizer RTL.
`timescale 1ns / 1ps

module tb_midpoint_ellipse_rasterizer;

  localparam int CB           = 10;
  localparam int RB           = 9;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct packed {
    logic          action;
    logic [CB-1:0] center_x;
    logic [CB-1:0] center_y;
    logic [RB-1:0] radius_x;
    logic [RB-1:0] radius_y;
  } cmd_item_t;

  typedef struct packed {
    logic signed [CB+1:0] right_x;
    logic signed [CB+1:0] left_x;
    logic signed [CB+1:0] lower_y;
    logic signed [CB+1:0] upper_y;
    logic [RB-1:0]        offset_x;
    logic [RB-1:0]        offset_y;
    logic                 point_valid;
    logic                 last;
  } point_t;

  logic clk = 1'b0;
  logic rst;

  mer_in_if  #(.COORD_BITS(CB), .RADIUS_BITS(RB)) cmd_if ();
  mer_out_if #(.COORD_BITS(CB), .RADIUS_BITS(RB)) pix_if ();

  midpoint_ellipse_rasterizer #(.COORD_BITS(CB), .RADIUS_BITS(RB)) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .pix (pix_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted ellipse state, kept in 64 bits, wider than the decision arithmetic it mirrors
  logic [63:0] e_ccol, e_crow, e_rxsq, e_rysq;
  logic [63:0] e_x, e_y, e_sx, e_sy, e_dec;
  bit          e_r2, e_active;

  point_t expected_points[$];
  int     error_count  = 0;
  int     items_sent   = 0;
  bit     src_idle_on  = 1'b1;
  bit     sink_idle_on = 1'b1;
  int     hold_reqs    = 0;
  int     holds_served = 0;

  function automatic point_t next_point(input cmd_item_t it);
    point_t      p;
    logic [63:0] rx, ry, tx, ty;
    bit          fin;
    p = '0;
    if (it.action == mer_pkg::ACT_START) begin
      rx       = 64'(it.radius_x);
      ry       = 64'(it.radius_y);
      e_ccol   = 64'(it.center_x);
      e_crow   = 64'(it.center_y);
      e_rxsq   = rx * rx;
      e_rysq   = ry * ry;
      e_x      = '0;
      e_y      = ry;
      e_sx     = '0;
      e_sy     = 2 * e_rxsq * ry;
      e_dec    = 4 * e_rysq - 4 * e_rxsq * ry + e_rxsq;
      e_r2     = 1'b0;
      e_active = (ry != 0);
      fin      = (ry == 0);
    end else if (!e_active) begin
      return p;
    end else begin
      if (!e_r2 && e_sx < e_sy) begin
        e_x  = (e_x + 1) & ((64'd1 << RB) - 1);
        e_sx = e_sx + 2 * e_rysq;
        if (e_dec[63]) begin
          e_dec = e_dec + 4 * (e_rysq + e_sx);
        end else begin
          e_y   = e_y - 1;
          e_sy  = e_sy - 2 * e_rxsq;
          e_dec = e_dec + 4 * (e_rysq + e_sx - e_sy);
        end
      end else begin
        // crossing into region 2 rebuilds the decision, then steps once
        if (!e_r2) begin
          tx    = 2 * e_x + 1;
          ty    = e_y - 1;
          e_dec = e_rysq * tx * tx + 4 * e_rxsq * ty * ty - 4 * e_rxsq * e_rysq;
          e_r2  = 1'b1;
        end
        e_y  = e_y - 1;
        e_sy = e_sy - 2 * e_rxsq;
        if (!e_dec[63] && e_dec != 0) begin
          e_dec = e_dec + 4 * (e_rxsq - e_sy);
        end else begin
          e_x   = (e_x + 1) & ((64'd1 << RB) - 1);
          e_sx  = e_sx + 2 * e_rysq;
          e_dec = e_dec + 4 * (e_rxsq - e_sy + e_sx);
        end
      end
      fin = (e_y == 0);
      if (fin) e_active = 1'b0;
    end
    p.right_x     = (CB+2)'(e_ccol + e_x);
    p.left_x      = (CB+2)'(e_ccol - e_x);
    p.lower_y     = (CB+2)'(e_crow + e_y);
    p.upper_y     = (CB+2)'(e_crow - e_y);
    p.offset_x    = RB'(e_x);
    p.offset_y    = RB'(e_y);
    p.point_valid = 1'b1;
    p.last        = fin;
    return p;
  endfunction

  function automatic cmd_item_t random_item(input logic act);
    cmd_item_t it;
    it.action   = act;
    it.center_x = CB'($urandom_range(0, (1 << CB) - 1));
    it.center_y = CB'($urandom_range(0, (1 << CB) - 1));
    it.radius_x = RB'($urandom_range(0, (1 << RB) - 1));
    it.radius_y = RB'($urandom_range(0, (1 << RB) - 1));
    return it;
  endfunction

  task automatic send_item(input cmd_item_t it);
    int gap;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.action   <= it.action;
    cmd_if.center_x <= it.center_x;
    cmd_if.center_y <= it.center_y;
    cmd_if.radius_x <= it.radius_x;
    cmd_if.radius_y <= it.radius_y;
    do @(posedge clk); while (!cmd_if.ready);
    expected_points.push_back(next_point(it));
    items_sent++;
  endtask

  task automatic send_start(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                            input logic [RB-1:0] rx, input logic [RB-1:0] ry);
    cmd_item_t it;
    it          = random_item(mer_pkg::ACT_START);
    it.center_x = cx;
    it.center_y = cy;
    it.radius_x = rx;
    it.radius_y = ry;
    send_item(it);
  endtask

  task automatic send_advance();
    send_item(random_item(mer_pkg::ACT_ADVANCE));
  endtask

  task automatic trace_ellipse(input int max_steps);
    for (int i = 0; i < max_steps && e_active; i++) send_advance();
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_advance();
    send_advance();
    send_advance();
  endtask

  task automatic test_zero_radius();
    send_start('1, '0, '1, '0);
    send_advance();
    send_start('0, '1, '0, '0);
  endtask

  task automatic test_corner_extremes();
    send_start('1, '1, '1, '1);
    trace_ellipse(3);
    // abandon mid-curve; offsets drive left_x/upper_y negative
    send_start('0, '0, '1, '1);
    trace_ellipse(3);
  endtask

  task automatic test_degenerate_axes();
    send_start(CB'(500), CB'(20), '0, RB'(4));
    trace_ellipse(10);
    send_start(CB'(3), CB'(1000), RB'(3), RB'(1));
    trace_ellipse(10);
    send_advance();
  endtask

  task automatic test_region_switch();
    send_start(CB'(200), CB'(300), RB'(6), RB'(3));
    trace_ellipse(20);
  endtask

  task automatic test_widest_ellipse();
    send_start(CB'($urandom_range(0, (1 << CB) - 1)),
               CB'($urandom_range(0, (1 << CB) - 1)), '1, '1);
    trace_ellipse(100000);
  endtask

  task automatic test_random_ellipses(input int n_items);
    int stop_at, kind;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_advance();
      end else if (kind == 1) begin
        // full-width radii, cut short to keep the run bounded
        send_start(CB'($urandom_range(0, (1 << CB) - 1)),
                   CB'($urandom_range(0, (1 << CB) - 1)),
                   RB'($urandom_range(0, (1 << RB) - 1)),
                   RB'($urandom_range(0, (1 << RB) - 1)));
        trace_ellipse($urandom_range(0, 12));
      end else begin
        send_start(CB'($urandom_range(0, (1 << CB) - 1)),
                   CB'($urandom_range(0, (1 << CB) - 1)),
                   RB'($urandom_range(0, 24)), RB'($urandom_range(0, 24)));
        trace_ellipse(kind == 2 ? $urandom_range(0, 6) : 100000);
      end
    end
  endtask

  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    hold_reqs++;
    send_start(CB'(512), CB'(512), RB'(40), RB'(30));
    trace_ellipse(40);
    src_idle_on = 1'b1;
  endtask

  task automatic test_streaming();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_ellipses(250);
  endtask

  // ---------------------------------------------------------------- sink side

  initial begin
    int burst;
    pix_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        pix_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        pix_if.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  point_t got, want;

  always @(posedge clk) begin
    if (!rst && pix_if.valid && pix_if.ready) begin
      got.right_x     = pix_if.right_x;
      got.left_x      = pix_if.left_x;
      got.lower_y     = pix_if.lower_y;
      got.upper_y     = pix_if.upper_y;
      got.offset_x    = pix_if.offset_x;
      got.offset_y    = pix_if.offset_y;
      got.point_valid = pix_if.point_valid;
      got.last        = pix_if.last;
      if (expected_points.size() == 0) begin
        if (error_count < 10)
          $display("unexpected point record: x=%0d/%0d y=%0d/%0d", got.right_x,
                   got.left_x, got.lower_y, got.upper_y);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (got.right_x !== want.right_x || got.left_x !== want.left_x ||
            got.lower_y !== want.lower_y || got.upper_y !== want.upper_y ||
            got.offset_x !== want.offset_x || got.offset_y !== want.offset_y ||
            got.point_valid !== want.point_valid || got.last !== want.last) begin
          if (error_count < 10) begin
            $display("mismatch exp: rx=%0d lx=%0d ly=%0d uy=%0d ox=%0d oy=%0d pv=%b last=%b",
                     want.right_x, want.left_x, want.lower_y, want.upper_y,
                     want.offset_x, want.offset_y, want.point_valid, want.last);
            $display("         got: rx=%0d lx=%0d ly=%0d uy=%0d ox=%0d oy=%0d pv=%b last=%b",
                     got.right_x, got.left_x, got.lower_y, got.upper_y,
                     got.offset_x, got.offset_y, got.point_valid, got.last);
          end
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst             <= 1'b1;
    cmd_if.valid    <= 1'b0;
    cmd_if.action   <= mer_pkg::ACT_START;
    cmd_if.center_x <= '0;
    cmd_if.center_y <= '0;
    cmd_if.radius_x <= '0;
    cmd_if.radius_y <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_idle_advance();
    test_zero_radius();
    test_corner_extremes();
    test_degenerate_axes();
    test_region_switch();
    test_widest_ellipse();
    test_random_ellipses(350);
    test_output_backpressure();
    test_random_ellipses(100);
    test_streaming();
    wait_drained();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
